// File: hdl/ecpasm_pkg.sv
// Shared types and codes for the elliptic-curve point add / scalar multiply block.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none
package ecpasm_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_A     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_ORDER = 2'd2;
  localparam int GO_W = 32;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_RED, OP_ADD, OP_SUB, OP_MUL, OP_KRED, OP_KSHIFT,
    OP_INV_INIT, OP_ESHIFT, OP_A_INIT, OP_A_GETS_D, OP_WR_RES, OP_RES_INF, OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    RS_DX, RS_DY, RS_AX, RS_AY, RS_T, RS_U, RS_LAM, RS_XR, RS_IR, RS_IB, RS_CA
  } rsel_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_RDX, ST_RDY, ST_RAX, ST_RAY, ST_RCA,
    ST_KRED, ST_AINIT, ST_KSH, ST_MLOOP, ST_MACC,
    ST_AD_CHK, ST_AD_CPY, ST_AD_INF,
    ST_AD_D1, ST_AD_D2, ST_AD_D3, ST_AD_D4, ST_AD_D5, ST_AD_C1, ST_AD_C2,
    ST_IV_INIT, ST_IV_CHK, ST_IV_M1, ST_IV_M2, ST_IV_SH,
    ST_AD_LAM, ST_AD_F1, ST_AD_F2, ST_AD_F3, ST_AD_F4, ST_AD_F5, ST_AD_F6, ST_AD_F7,
    ST_FIN
  } state_t;

  typedef struct packed {
    op_t   op;
    rsel_t sa;
    rsel_t sb;
    rsel_t dst;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic e_zero;
    logic e_lsb;
    logic k_zero;
    logic k_lsb;
    logic eq_x;
    logic eq_y;
    logic dy_zero;
    logic d_inf;
    logic a_inf;
    logic func;
  } stat_t;

endpackage
`default_nettype wire

// File: hdl/ecpasm_dp.sv
// Datapath: config registers, point/temporary registers, add/sub unit and
// bit-serial modular multiplier/reducer. Depends on ecpasm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ecpasm_dp
  import ecpasm_pkg::*;
#(
  parameter int FIELD_BITS  = 31,
  parameter int SCALAR_BITS = 63,
  localparam int CFG_W = (FIELD_BITS > GO_W) ? FIELD_BITS : GO_W
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_wdata,
  input  wire logic                   in_func,
  input  wire logic [FIELD_BITS-1:0]  in_first_x,
  input  wire logic [FIELD_BITS-1:0]  in_first_y,
  input  wire logic                   in_first_is_infinity,
  input  wire logic [FIELD_BITS-1:0]  in_second_x,
  input  wire logic [FIELD_BITS-1:0]  in_second_y,
  input  wire logic                   in_second_is_infinity,
  input  wire logic [SCALAR_BITS-1:0] in_scalar,
  input  wire cmd_t                   cmd,
  output stat_t                       st,
  output logic [FIELD_BITS-1:0]       out_result_x,
  output logic [FIELD_BITS-1:0]       out_result_y,
  output logic                        out_result_is_infinity
);

  localparam int FB   = FIELD_BITS;
  localparam int SB   = SCALAR_BITS;
  localparam int MAXB = (FB > SB) ? FB : SB;
  localparam int CW   = $clog2(MAXB);
  localparam logic [63:0] MOD_RST64 = 64'd2147483647;
  localparam logic [FB-1:0] MOD_RST = MOD_RST64[FB-1:0];

  logic [FB-1:0] ca_cfg_r, mod_r;
  logic [GO_W-1:0] go_r;

  logic [FB-1:0] dx_r, dy_r, ax_r, ay_r, t_r, u_r, lam_r, xr_r, ir_r, ib_r, ca_r, e_r;
  logic          dinf_r, ainf_r, func_r;
  logic [SB-1:0] k_r;
  logic [FB-1:0] acc_r, sh_r;
  logic [GO_W-1:0] kr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [FB-1:0] ox_r, oy_r;
  logic          oinf_r;

  logic [FB-1:0] m, opa, opb;
  logic [FB:0]   mext;
  logic          first, last_f, last_k, go_le1, done, serial_op, alu_wr;
  logic [FB-1:0] r_cur, b_cur, addend, mul_res, add_res, sub_res, res;
  logic          bit_c;
  logic [FB:0]   d2, r1, s2, r2, sum, sum_red;
  logic [GO_W-1:0] kr_cur, kres;
  logic [GO_W:0]   kt, kn, go_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_cfg_r <= '0;
      mod_r    <= MOD_RST;
      go_r     <= GO_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CURVE_A:     ca_cfg_r <= cfg_wdata[FB-1:0];
        CFG_MODULUS:     mod_r    <= cfg_wdata[FB-1:0];
        CFG_GROUP_ORDER: go_r     <= cfg_wdata[GO_W-1:0];
        default: ;
      endcase
    end
  end

  assign m      = (mod_r == '0) ? FB'(1) : mod_r;
  assign mext   = {1'b0, m};
  assign go_le1 = (go_r <= GO_W'(1));

  always_comb begin
    unique case (cmd.sa)
      RS_DX:   opa = dx_r;
      RS_DY:   opa = dy_r;
      RS_AX:   opa = ax_r;
      RS_AY:   opa = ay_r;
      RS_T:    opa = t_r;
      RS_U:    opa = u_r;
      RS_LAM:  opa = lam_r;
      RS_XR:   opa = xr_r;
      RS_IR:   opa = ir_r;
      RS_IB:   opa = ib_r;
      RS_CA:   opa = ca_r;
      default: opa = '0;
    endcase
    unique case (cmd.sb)
      RS_DX:   opb = dx_r;
      RS_DY:   opb = dy_r;
      RS_AX:   opb = ax_r;
      RS_AY:   opb = ay_r;
      RS_T:    opb = t_r;
      RS_U:    opb = u_r;
      RS_LAM:  opb = lam_r;
      RS_XR:   opb = xr_r;
      RS_IR:   opb = ir_r;
      RS_IB:   opb = ib_r;
      RS_CA:   opb = ca_r;
      default: opb = '0;
    endcase
  end

  // one multiplier bit per cycle, MSB first: r = 2r (+a) mod m
  assign first  = (cnt_r == '0);
  assign last_f = (cnt_r == CW'(FB - 1));
  assign last_k = (cnt_r == CW'(SB - 1));
  assign r_cur  = first ? '0 : acc_r;
  assign b_cur  = first ? opb : sh_r;
  assign bit_c  = b_cur[FB-1];
  assign d2     = {r_cur, 1'b0};
  assign r1     = (d2 >= mext) ? d2 - mext : d2;
  assign addend = !bit_c ? '0 : ((cmd.op == OP_RED) ? FB'(1) : opa);
  assign s2     = r1 + {1'b0, addend};
  assign r2     = (s2 >= mext) ? s2 - mext : s2;
  assign mul_res = r2[FB-1:0];

  assign sum     = {1'b0, opa} + {1'b0, opb};
  assign sum_red = (sum >= mext) ? sum - mext : sum;
  assign add_res = sum_red[FB-1:0];
  assign sub_res = (opa >= opb) ? opa - opb : opa - opb + m;

  // scalar remainder, one scalar bit per cycle
  assign go_ext = {1'b0, go_r};
  assign kr_cur = first ? '0 : kr_r;
  assign kt     = {kr_cur, k_r[SB-1]};
  assign kn     = (kt >= go_ext) ? kt - go_ext : kt;
  assign kres   = kn[GO_W-1:0];

  always_comb begin
    unique case (cmd.op)
      OP_MUL, OP_RED: done = last_f;
      OP_KRED:        done = go_le1 | last_k;
      default:        done = 1'b1;
    endcase
  end

  assign serial_op = (cmd.op == OP_MUL) || (cmd.op == OP_RED) ||
                     ((cmd.op == OP_KRED) && !go_le1);
  assign cnt_nxt   = (serial_op && !done) ? cnt_r + CW'(1) : '0;
  assign alu_wr    = done && ((cmd.op == OP_ADD) || (cmd.op == OP_SUB) ||
                              (cmd.op == OP_MUL) || (cmd.op == OP_RED));

  always_comb begin
    unique case (cmd.op)
      OP_ADD:  res = add_res;
      OP_SUB:  res = sub_res;
      default: res = mul_res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    acc_r <= mul_res;
    sh_r  <= b_cur << 1;
    if (alu_wr) begin
      unique case (cmd.dst)
        RS_DX:   dx_r  <= res;
        RS_DY:   dy_r  <= res;
        RS_AX:   ax_r  <= res;
        RS_AY:   ay_r  <= res;
        RS_T:    t_r   <= res;
        RS_U:    u_r   <= res;
        RS_LAM:  lam_r <= res;
        RS_XR:   xr_r  <= res;
        RS_IR:   ir_r  <= res;
        RS_IB:   ib_r  <= res;
        RS_CA:   ca_r  <= res;
        default: ;
      endcase
    end
    unique case (cmd.op)
      OP_LOAD: begin
        dx_r   <= in_first_x;
        dy_r   <= in_first_y;
        dinf_r <= in_first_is_infinity;
        ax_r   <= in_second_x;
        ay_r   <= in_second_y;
        ainf_r <= in_second_is_infinity;
        k_r    <= in_scalar;
        ca_r   <= ca_cfg_r;
        func_r <= in_func;
      end
      OP_KRED: begin
        if (!go_le1) begin
          kr_r <= kres;
          k_r  <= last_k ? SB'(kres) : (k_r << 1);
        end
      end
      OP_KSHIFT: k_r <= k_r >> 1;
      OP_INV_INIT: begin
        ir_r <= (m == FB'(1)) ? '0 : FB'(1);
        ib_r <= opa;
        e_r  <= (m >= FB'(2)) ? m - FB'(2) : '0;
      end
      OP_ESHIFT: e_r <= e_r >> 1;
      OP_A_INIT: begin
        ax_r   <= k_r[0] ? dx_r : '0;
        ay_r   <= k_r[0] ? dy_r : '0;
        ainf_r <= k_r[0] ? dinf_r : 1'b1;
      end
      OP_A_GETS_D: begin
        ax_r   <= dx_r;
        ay_r   <= dy_r;
        ainf_r <= dinf_r;
      end
      OP_WR_RES: begin
        if (cmd.dst == RS_DX) begin
          dx_r   <= xr_r;
          dy_r   <= t_r;
          dinf_r <= 1'b0;
        end else begin
          ax_r   <= xr_r;
          ay_r   <= t_r;
          ainf_r <= 1'b0;
        end
      end
      OP_RES_INF: begin
        if (cmd.dst == RS_DX) begin
          dx_r   <= '0;
          dy_r   <= '0;
          dinf_r <= 1'b1;
        end else begin
          ax_r   <= '0;
          ay_r   <= '0;
          ainf_r <= 1'b1;
        end
      end
      OP_OUT: begin
        ox_r   <= ainf_r ? '0 : ax_r;
        oy_r   <= ainf_r ? '0 : ay_r;
        oinf_r <= ainf_r;
      end
      default: ;
    endcase
  end

  assign st.done    = done;
  assign st.e_zero  = (e_r == '0);
  assign st.e_lsb   = e_r[0];
  assign st.k_zero  = (k_r == '0);
  assign st.k_lsb   = k_r[0];
  assign st.eq_x    = (dx_r == ax_r);
  assign st.eq_y    = (dy_r == ay_r);
  assign st.dy_zero = (dy_r == '0);
  assign st.d_inf   = dinf_r;
  assign st.a_inf   = ainf_r;
  assign st.func    = func_r;

  assign out_result_x           = ox_r;
  assign out_result_y           = oy_r;
  assign out_result_is_infinity = oinf_r;

endmodule
`default_nettype wire

// File: hdl/ecpasm_ctrl.sv
// Controller: sequences reduction, point add, Fermat inversion and
// double-and-add over the datapath. Depends on ecpasm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ecpasm_ctrl
  import ecpasm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  wire logic  out_stall,
  input  wire stat_t st,
  output cmd_t       cmd
);

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic   dbl_r, dbl_nxt, out_valid_r, out_valid_nxt;
  logic   out_free, q_inf, eqx, eqy;
  rsel_t  qx, qy;

  assign out_free = !out_valid_r || !out_stall;
  assign q_inf    = dbl_r ? st.d_inf : st.a_inf;
  assign eqx      = dbl_r || st.eq_x;
  assign eqy      = dbl_r || st.eq_y;
  assign qx       = dbl_r ? RS_DX : RS_AX;
  assign qy       = dbl_r ? RS_DY : RS_AY;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_FIN;
      dbl_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      dbl_r       <= dbl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    dbl_nxt       = dbl_r;
    out_valid_nxt = out_valid_r;
    if (!out_stall) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_RDX;
      ST_RDX:  if (st.done) state_nxt = ST_RDY;
      ST_RDY:  if (st.done) state_nxt = ST_RAX;
      ST_RAX:  if (st.done) state_nxt = ST_RAY;
      ST_RAY:  if (st.done) state_nxt = ST_RCA;
      ST_RCA: begin
        if (st.done) begin
          if (st.func) begin
            state_nxt = ST_KRED;
          end else begin
            dbl_nxt   = 1'b0;
            ret_nxt   = ST_FIN;
            state_nxt = ST_AD_CHK;
          end
        end
      end
      ST_KRED:  if (st.done) state_nxt = ST_AINIT;
      ST_AINIT: state_nxt = ST_KSH;
      ST_KSH:   state_nxt = ST_MLOOP;
      ST_MLOOP: begin
        if (st.k_zero) begin
          state_nxt = ST_FIN;
        end else begin
          dbl_nxt   = 1'b1;
          ret_nxt   = ST_MACC;
          state_nxt = ST_AD_CHK;
        end
      end
      ST_MACC: begin
        if (st.k_lsb) begin
          dbl_nxt   = 1'b0;
          ret_nxt   = ST_KSH;
          state_nxt = ST_AD_CHK;
        end else begin
          state_nxt = ST_KSH;
        end
      end
      ST_AD_CHK: begin
        priority if (st.d_inf) state_nxt = ret_r;
        else if (q_inf)        state_nxt = ST_AD_CPY;
        else if (eqx) begin
          if (!eqy || st.dy_zero) state_nxt = ST_AD_INF;
          else                    state_nxt = ST_AD_D1;
        end else                 state_nxt = ST_AD_C1;
      end
      ST_AD_CPY, ST_AD_INF, ST_AD_F7: state_nxt = ret_r;
      ST_AD_D1: if (st.done) state_nxt = ST_AD_D2;
      ST_AD_D2: state_nxt = ST_AD_D3;
      ST_AD_D3: state_nxt = ST_AD_D4;
      ST_AD_D4: state_nxt = ST_AD_D5;
      ST_AD_D5: state_nxt = ST_IV_INIT;
      ST_AD_C1: state_nxt = ST_AD_C2;
      ST_AD_C2: state_nxt = ST_IV_INIT;
      ST_IV_INIT: state_nxt = ST_IV_CHK;
      ST_IV_CHK: begin
        priority if (st.e_zero) state_nxt = ST_AD_LAM;
        else if (st.e_lsb)      state_nxt = ST_IV_M1;
        else                    state_nxt = ST_IV_M2;
      end
      ST_IV_M1:  if (st.done) state_nxt = ST_IV_M2;
      ST_IV_M2:  if (st.done) state_nxt = ST_IV_SH;
      ST_IV_SH:  state_nxt = ST_IV_CHK;
      ST_AD_LAM: if (st.done) state_nxt = ST_AD_F1;
      ST_AD_F1:  if (st.done) state_nxt = ST_AD_F2;
      ST_AD_F2:  state_nxt = ST_AD_F3;
      ST_AD_F3:  state_nxt = ST_AD_F4;
      ST_AD_F4:  state_nxt = ST_AD_F5;
      ST_AD_F5:  if (st.done) state_nxt = ST_AD_F6;
      ST_AD_F6:  state_nxt = ST_AD_F7;
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '{op: OP_NONE, sa: RS_DX, sb: RS_DX, dst: RS_DX};
    in_stall = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE:    if (in_valid) cmd.op = OP_LOAD;
      ST_RDX:     cmd = '{op: OP_RED, sa: RS_DX, sb: RS_DX, dst: RS_DX};
      ST_RDY:     cmd = '{op: OP_RED, sa: RS_DY, sb: RS_DY, dst: RS_DY};
      ST_RAX:     cmd = '{op: OP_RED, sa: RS_AX, sb: RS_AX, dst: RS_AX};
      ST_RAY:     cmd = '{op: OP_RED, sa: RS_AY, sb: RS_AY, dst: RS_AY};
      ST_RCA:     cmd = '{op: OP_RED, sa: RS_CA, sb: RS_CA, dst: RS_CA};
      ST_KRED:    cmd.op = OP_KRED;
      ST_AINIT:   cmd.op = OP_A_INIT;
      ST_KSH:     cmd.op = OP_KSHIFT;
      ST_AD_CPY:  cmd.op = OP_A_GETS_D;
      ST_AD_INF:  cmd = '{op: OP_RES_INF, sa: RS_DX, sb: RS_DX, dst: qx};
      ST_AD_D1:   cmd = '{op: OP_MUL, sa: RS_DX, sb: RS_DX, dst: RS_T};
      ST_AD_D2:   cmd = '{op: OP_ADD, sa: RS_T, sb: RS_T, dst: RS_U};
      ST_AD_D3:   cmd = '{op: OP_ADD, sa: RS_U, sb: RS_T, dst: RS_U};
      ST_AD_D4:   cmd = '{op: OP_ADD, sa: RS_U, sb: RS_CA, dst: RS_T};
      ST_AD_D5:   cmd = '{op: OP_ADD, sa: RS_DY, sb: RS_DY, dst: RS_U};
      ST_AD_C1:   cmd = '{op: OP_SUB, sa: qy, sb: RS_DY, dst: RS_T};
      ST_AD_C2:   cmd = '{op: OP_SUB, sa: qx, sb: RS_DX, dst: RS_U};
      ST_IV_INIT: cmd = '{op: OP_INV_INIT, sa: RS_U, sb: RS_U, dst: RS_IB};
      ST_IV_M1:   cmd = '{op: OP_MUL, sa: RS_IR, sb: RS_IB, dst: RS_IR};
      ST_IV_M2:   cmd = '{op: OP_MUL, sa: RS_IB, sb: RS_IB, dst: RS_IB};
      ST_IV_SH:   cmd.op = OP_ESHIFT;
      ST_AD_LAM:  cmd = '{op: OP_MUL, sa: RS_T, sb: RS_IR, dst: RS_LAM};
      ST_AD_F1:   cmd = '{op: OP_MUL, sa: RS_LAM, sb: RS_LAM, dst: RS_T};
      ST_AD_F2:   cmd = '{op: OP_ADD, sa: RS_DX, sb: qx, dst: RS_U};
      ST_AD_F3:   cmd = '{op: OP_SUB, sa: RS_T, sb: RS_U, dst: RS_XR};
      ST_AD_F4:   cmd = '{op: OP_SUB, sa: RS_DX, sb: RS_XR, dst: RS_U};
      ST_AD_F5:   cmd = '{op: OP_MUL, sa: RS_LAM, sb: RS_U, dst: RS_T};
      ST_AD_F6:   cmd = '{op: OP_SUB, sa: RS_T, sb: RS_DY, dst: RS_T};
      ST_AD_F7:   cmd = '{op: OP_WR_RES, sa: RS_DX, sb: RS_DX, dst: qx};
      ST_FIN:     if (out_free) cmd.op = OP_OUT;
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_RDX))
    else $error("accepted beat did not start reduction");
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside finish state");
  a_ret_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_AD_CHK) |-> (ret_r == ST_FIN || ret_r == ST_MACC || ret_r == ST_KSH))
    else $error("bad return state for point add");
`endif

endmodule
`default_nettype wire

// File: hdl/ec_point_add_and_scalar_multiply_top.sv
// Top level: elliptic-curve point add and scalar multiply over a prime field.
// Depends on ecpasm_pkg, ecpasm_ctrl and ecpasm_dp.
//
//   channel | handshake           | payload
//   in      | in_valid / in_stall | func, first/second point, scalar
//   out     | out_valid/out_stall | result_x, result_y, result_is_infinity
//   cfg     | cfg_we              | cfg_index, cfg_wdata
//
// One item at a time. A modular multiply runs on the shared bit-serial
// multiplier; an inversion takes up to 2*FIELD_BITS multiplies. A scalar
// multiply adds a scalar reduction and up to 2*SCALAR_BITS point adds.
// Reset sets curve_a 0, modulus 2^31-1, group_order 1. A new beat is taken while
// a finished result waits on out_stall.
`timescale 1ns / 1ps
`default_nettype none
module ec_point_add_and_scalar_multiply_top
  import ecpasm_pkg::*;
#(
  parameter int FIELD_BITS  = 31,
  parameter int SCALAR_BITS = 63,
  localparam int CFG_W = (FIELD_BITS > GO_W) ? FIELD_BITS : GO_W
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_wdata,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   in_func,
  input  wire logic [FIELD_BITS-1:0]  in_first_x,
  input  wire logic [FIELD_BITS-1:0]  in_first_y,
  input  wire logic                   in_first_is_infinity,
  input  wire logic [FIELD_BITS-1:0]  in_second_x,
  input  wire logic [FIELD_BITS-1:0]  in_second_y,
  input  wire logic                   in_second_is_infinity,
  input  wire logic [SCALAR_BITS-1:0] in_scalar,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [FIELD_BITS-1:0]       out_result_x,
  output logic [FIELD_BITS-1:0]       out_result_y,
  output logic                        out_result_is_infinity
);

  cmd_t  cmd;
  stat_t st;

  ecpasm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  ecpasm_dp #(
    .FIELD_BITS  (FIELD_BITS),
    .SCALAR_BITS (SCALAR_BITS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_func                (in_func),
    .in_first_x             (in_first_x),
    .in_first_y             (in_first_y),
    .in_first_is_infinity   (in_first_is_infinity),
    .in_second_x            (in_second_x),
    .in_second_y            (in_second_y),
    .in_second_is_infinity  (in_second_is_infinity),
    .in_scalar              (in_scalar),
    .cmd                    (cmd),
    .st                     (st),
    .out_result_x           (out_result_x),
    .out_result_y           (out_result_y),
    .out_result_is_infinity (out_result_is_infinity)
  );

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for ec_point_add_and_scalar_multiply_top.
// It needs ecpasm_pkg and the RTL. Each result beat is checked against a table
// value or an internal point-arithmetic predictor, across several curve settings.
`timescale 1ns / 1ps
module testbench;
  import ecpasm_pkg::*;

  localparam int FB = 31;
  localparam int KB = 63;
  localparam int CW = 32;
  localparam logic [FB-1:0] ONES = {FB{1'b1}};
  localparam int WDOG_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 15000;

  typedef logic [63:0] u64_t;
  typedef enum logic {FN_ADD, FN_MUL} fn_t;

  typedef struct packed {
    fn_t func;
    logic [FB-1:0] fx;
    logic [FB-1:0] fy;
    logic finf;
    logic [FB-1:0] sx;
    logic [FB-1:0] sy;
    logic sinf;
    logic [KB-1:0] k;
  } pt_req_t;

  typedef struct packed {
    logic [FB-1:0] x;
    logic [FB-1:0] y;
    logic inf;
  } pt_res_t;

  typedef struct packed {
    pt_req_t req;
    logic known;
    pt_res_t res;
  } dir_row_t;

  typedef struct packed {
    u64_t x;
    u64_t y;
    logic inf;
  } ecp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = 1'b0;
  logic [FB-1:0] in_first_x = '0, in_first_y = '0, in_second_x = '0, in_second_y = '0;
  logic in_first_is_infinity = 1'b0, in_second_is_infinity = 1'b0;
  logic [KB-1:0] in_scalar = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [FB-1:0] out_result_x, out_result_y;
  logic out_result_is_infinity;

  ec_point_add_and_scalar_multiply_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_first_x(in_first_x), .in_first_y(in_first_y),
    .in_first_is_infinity(in_first_is_infinity),
    .in_second_x(in_second_x), .in_second_y(in_second_y),
    .in_second_is_infinity(in_second_is_infinity), .in_scalar(in_scalar),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_x(out_result_x), .out_result_y(out_result_y),
    .out_result_is_infinity(out_result_is_infinity)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [FB-1:0] cur_a = '0;
  logic [FB-1:0] cur_mod = 31'h7FFFFFFF;
  logic [CW-1:0] cur_order = 32'd1;

  pt_res_t point_q[$];
  int err_cnt = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int wdog = 0;

  // modular arithmetic on 64-bit carriers; operands stay below m < 2^31
  function automatic u64_t fld_add(u64_t a, u64_t b, u64_t m);
    u64_t s;
    s = a + b;
    return (s >= m) ? s - m : s;
  endfunction

  function automatic u64_t fld_sub(u64_t a, u64_t b, u64_t m);
    return (a >= b) ? a - b : a + (m - b);
  endfunction

  function automatic u64_t fld_mul(u64_t a, u64_t b, u64_t m);
    u64_t r;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = fld_add(r, r, m);
      if (b[i]) r = fld_add(r, a, m);
    end
    return r;
  endfunction

  function automatic u64_t fld_inv(u64_t v, u64_t m);
    u64_t e, r, b;
    e = (m >= 2) ? m - 2 : 0;
    r = 1 % m;
    b = v;
    while (e != 0) begin
      if (e[0]) r = fld_mul(r, b, m);
      b = fld_mul(b, b, m);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic ecp_t ec_add(ecp_t p, ecp_t q, u64_t a, u64_t m);
    ecp_t r;
    u64_t lam, t;
    if (p.inf) return q;
    if (q.inf) return p;
    r = '{x: 0, y: 0, inf: 1'b1};
    if (p.x == q.x) begin
      if (p.y != q.y || p.y == 0) return r;
      t = fld_mul(p.x, p.x, m);
      t = fld_add(fld_add(fld_add(t, t, m), t, m), a, m);
      lam = fld_mul(t, fld_inv(fld_add(p.y, p.y, m), m), m);
    end else begin
      lam = fld_mul(fld_sub(q.y, p.y, m), fld_inv(fld_sub(q.x, p.x, m), m), m);
    end
    r.inf = 1'b0;
    r.x = fld_sub(fld_mul(lam, lam, m), fld_add(p.x, q.x, m), m);
    r.y = fld_sub(fld_mul(lam, fld_sub(p.x, r.x, m), m), p.y, m);
    return r;
  endfunction

  function automatic ecp_t ec_scale(ecp_t p, u64_t k, u64_t a, u64_t m);
    ecp_t acc, dbl;
    acc = '{x: 0, y: 0, inf: 1'b1};
    if (k == 0) return acc;
    dbl = p;
    if (k[0]) acc = dbl;
    k = k >> 1;
    while (k != 0) begin
      dbl = ec_add(dbl, dbl, a, m);
      if (k[0]) acc = ec_add(dbl, acc, a, m);
      k = k >> 1;
    end
    return acc;
  endfunction

  function automatic pt_res_t predict_point(pt_req_t rq);
    u64_t m, a, k;
    ecp_t p, q, r;
    pt_res_t res;
    m = (cur_mod == 0) ? 64'd1 : u64_t'(cur_mod);
    a = u64_t'(cur_a) % m;
    p = '{x: u64_t'(rq.fx) % m, y: u64_t'(rq.fy) % m, inf: rq.finf};
    q = '{x: u64_t'(rq.sx) % m, y: u64_t'(rq.sy) % m, inf: rq.sinf};
    if (rq.func == FN_ADD) begin
      r = ec_add(p, q, a, m);
    end else begin
      k = u64_t'(rq.k);
      if (cur_order > 1) k = k % u64_t'(cur_order);
      r = ec_scale(p, k, a, m);
    end
    if (r.inf) res = '{x: '0, y: '0, inf: 1'b1};
    else res = '{x: r.x[FB-1:0], y: r.y[FB-1:0], inf: 1'b0};
    return res;
  endfunction

  function automatic pt_req_t rand_req();
    pt_req_t rq;
    u64_t m, yr;
    m = (cur_mod == 0) ? 64'd1 : u64_t'(cur_mod);
    rq.func = ($urandom_range(0, 9) < 3) ? FN_MUL : FN_ADD;
    rq.fx = FB'($urandom());
    rq.fy = FB'($urandom());
    rq.finf = ($urandom_range(0, 15) == 0);
    rq.sx = FB'($urandom());
    rq.sy = FB'($urandom());
    rq.sinf = 1'b0;
    case ($urandom_range(0, 9))
      4: begin
        rq.sx = rq.fx;
        rq.sy = rq.fy;
      end
      5: begin
        rq.fy = '0;
        rq.sx = rq.fx;
        rq.sy = '0;
      end
      6: begin
        yr = u64_t'(rq.fy) % m;
        rq.sx = rq.fx;
        rq.sy = FB'((m - yr) % m);
      end
      7: rq.sx = rq.fx;
      8: rq.finf = 1'b1;
      9: rq.sinf = 1'b1;
      default: ;
    endcase
    if (cur_order > 1 && cur_order <= 1000 && $urandom_range(0, 3) == 0)
      rq.k = KB'({$urandom(), $urandom()});
    else
      rq.k = KB'($urandom_range(0, 15));
    return rq;
  endfunction

  // call at a rising-edge step; returns at the edge that took the beat
  task automatic send_req(pt_req_t rq, logic known, pt_res_t res);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= rq.func;
    in_first_x <= rq.fx;
    in_first_y <= rq.fy;
    in_first_is_infinity <= rq.finf;
    in_second_x <= rq.sx;
    in_second_y <= rq.sy;
    in_second_is_infinity <= rq.sinf;
    in_scalar <= rq.k;
    do @(posedge clk); while (in_stall);
    point_q.push_back(known ? res : predict_point(rq));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (point_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_CURVE_A: cur_a = val[FB-1:0];
      CFG_MODULUS: cur_mod = val[FB-1:0];
      CFG_GROUP_ORDER: cur_order = val;
      default: ;
    endcase
  endtask

  task automatic set_curve(logic [CW-1:0] a, logic [CW-1:0] m, logic [CW-1:0] n);
    cfg_write(CFG_CURVE_A, a);
    cfg_write(CFG_MODULUS, m);
    cfg_write(CFG_GROUP_ORDER, n);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (point_q.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h inf=%b", $time, out_result_x,
                 out_result_y, out_result_is_infinity);
        err_cnt++;
      end else begin
        pt_res_t e;
        e = point_q.pop_front();
        if (e.x !== out_result_x || e.y !== out_result_y
            || e.inf !== out_result_is_infinity) begin
          $display("%0t: mismatch expected x=%h y=%h inf=%b actual x=%h y=%h inf=%b",
                   $time, e.x, e.y, e.inf, out_result_x, out_result_y,
                   out_result_is_infinity);
          err_cnt++;
        end
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  dir_row_t dir_tab [0:16] = '{
    '{'{FN_ADD, 31'd0, 31'd0, 1'b1, 31'd0, 31'd0, 1'b1, 63'd0}, 1'b1, '{31'd0, 31'd0, 1'b1}},
    '{'{FN_ADD, 31'd5, 31'd7, 1'b0, 31'd0, 31'd0, 1'b1, 63'd0}, 1'b1, '{31'd5, 31'd7, 1'b0}},
    '{'{FN_ADD, 31'd0, 31'd0, 1'b1, ONES, 31'd9, 1'b0, 63'd0}, 1'b1, '{31'd0, 31'd9, 1'b0}},
    '{'{FN_ADD, 31'd3, 31'd4, 1'b0, 31'd3, 31'd9, 1'b0, 63'd0}, 1'b1, '{31'd0, 31'd0, 1'b1}},
    '{'{FN_ADD, 31'd3, 31'd0, 1'b0, 31'd3, 31'd0, 1'b0, 63'd0}, 1'b1, '{31'd0, 31'd0, 1'b1}},
    '{'{FN_ADD, 31'd3, 31'd4, 1'b0, 31'd3, 31'd2147483643, 1'b0, 63'd0}, 1'b1,
      '{31'd0, 31'd0, 1'b1}},
    '{'{FN_MUL, 31'd11, 31'd12, 1'b0, 31'd0, 31'd0, 1'b0, 63'd0}, 1'b1, '{31'd0, 31'd0, 1'b1}},
    '{'{FN_MUL, 31'd11, 31'd12, 1'b0, 31'd0, 31'd0, 1'b0, 63'd1}, 1'b1,
      '{31'd11, 31'd12, 1'b0}},
    '{'{FN_MUL, 31'd11, 31'd12, 1'b1, 31'd0, 31'd0, 1'b0, 63'd5}, 1'b1, '{31'd0, 31'd0, 1'b1}},
    '{'{FN_MUL, 31'd3, 31'd0, 1'b0, 31'd0, 31'd0, 1'b0, 63'd2}, 1'b1, '{31'd0, 31'd0, 1'b1}},
    '{'{FN_ADD, ONES, ONES, 1'b0, 31'd0, 31'd1, 1'b0, 63'd0}, 1'b1, '{31'd0, 31'd0, 1'b1}},
    '{'{FN_ADD, 31'd1, 31'd2, 1'b0, 31'd3, 31'd4, 1'b0, 63'd0}, 1'b0, '0},
    '{'{FN_ADD, 31'd1, 31'd2, 1'b0, 31'd1, 31'd2, 1'b0, 63'd0}, 1'b0, '0},
    '{'{FN_ADD, 31'd2147483646, 31'd2147483646, 1'b0, 31'd0, 31'd0, 1'b0, 63'd0}, 1'b0, '0},
    '{'{FN_MUL, 31'd1, 31'd2, 1'b0, 31'd0, 31'd0, 1'b0, 63'd2}, 1'b0, '0},
    '{'{FN_MUL, 31'd5, 31'd7, 1'b0, ONES, ONES, 1'b1, 63'd3}, 1'b0, '0},
    '{'{FN_MUL, 31'd1, 31'd2, 1'b0, 31'd0, 31'd0, 1'b0, {KB{1'b1}}}, 1'b0, '0}
  };

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].known, dir_tab[i].res);
    drain();

    for (int ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: set_curve(32'd2147483646, 32'd2147483647, 32'hFFFFFFFF);
        2: set_curve(32'd5, 32'd97, 32'd1000);
        3: set_curve(32'h7FFFFFFF, 32'd3, 32'd0);
        4: set_curve(32'd1, 32'd0, 32'd7);
        default: set_curve(32'd0, 32'd2, 32'd2);
      endcase
      case (ph)
        1: begin snd_idle_pct = 65; rcv_stall_pct = 0; end
        2: begin snd_idle_pct = 0; rcv_stall_pct = 65; end
        3: begin snd_idle_pct = 19; rcv_stall_pct = 19; end
        default: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
      endcase
      if (ph == 3) hold_req = hold_req + 1;
      for (int n = 0; n < 18; n++) begin
        send_req(rand_req(), 1'b0, '0);
        if (ph == 4 && n == 8) begin
          in_valid <= 1'b0;
          while (point_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (err_cnt == 0 && point_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
